### hw/rtl/rbo_pkg.sv
package rbo_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned LabelBitsDef = 16;
  localparam int unsigned CfgBits      = 11;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned GainBits     = 9;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [CfgBits-1:0]  WidthReset  = 11'd640;
  localparam logic [CfgBits-1:0]  HeightReset = 11'd480;
  localparam logic [GainBits-1:0] GainReset   = 9'd230;
  localparam logic [7:0]          ChanMax     = 8'd255;

  typedef enum logic [CfgIdxBits-1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegDimGain     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CmdPixel = 1'b0,
    CmdDrain = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [15:0] region_label;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       on_boundary;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [CfgBits-1:0]  frame_width;
    logic [CfgBits-1:0]  frame_height;
    logic [GainBits-1:0] dim_gain;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        boundary;
    logic [23:0] rgb;
    logic        last;
  } work_t;

endpackage

### hw/rtl/rbo_front.sv
module rbo_front #(
  parameter int unsigned MaxWidth  = rbo_pkg::MaxWidthDef,
  parameter int unsigned LabelBits = rbo_pkg::LabelBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbo_pkg::cfg_t     cfg_i,
  input  logic              restart_i,
  input  logic              push_i,
  input  rbo_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output rbo_pkg::work_t    q_data_o
);

  localparam int unsigned CW = rbo_pkg::CfgBits;
  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned WB = $clog2(MaxWidth + 1);
  localparam int unsigned EW = (WB > CW) ? WB : CW;

  typedef struct packed {
    logic has_below;
    logic has_left;
    logic has_right;
    logic has_up;
    logic last;
  } nbr_t;

  logic [EW-1:0] fw_ext;
  logic [EW-1:0] eff_w;
  logic [CW-1:0] eff_h;

  logic [AW-1:0] col_q;
  logic [CW-1:0] row_q;
  logic          drain_q;

  logic [EW-1:0] col_nxt;
  logic [CW-1:0] row_nxt;
  logic          row_end;
  logic          has_right;
  logic          accept;
  logic          is_pix;
  logic          is_drn;
  logic          emit;
  logic          par;
  logic [AW-1:0] addr_c;
  logic [AW-1:0] addr_r;
  logic [LabelBits-1:0] lab_in;
  logic [23:0]   rgb_in;
  nbr_t          nbr_d;

  logic [LabelBits-1:0] bank0 [MaxWidth];
  logic [LabelBits-1:0] bank1 [MaxWidth];
  logic [23:0]          color_mem [MaxWidth];

  logic [LabelBits-1:0] b0_a_q, b0_b_q, b1_a_q, b1_b_q;
  logic [23:0]          color_rd_q;

  logic                 st_valid_q;
  logic                 st_go;
  nbr_t                 st_nbr_q;
  logic [LabelBits-1:0] st_below_q;
  logic                 st_par_q;
  logic [LabelBits-1:0] prev_me_q;

  logic [LabelBits-1:0] me;
  logic [LabelBits-1:0] right;
  logic [LabelBits-1:0] up;

  // frame geometry
  assign fw_ext = EW'(cfg_i.frame_width);

  always_comb begin
    if (fw_ext == '0) begin
      eff_w = EW'(1);
    end else if (fw_ext > EW'(MaxWidth)) begin
      eff_w = EW'(MaxWidth);
    end else begin
      eff_w = fw_ext;
    end
  end

  assign eff_h = (cfg_i.frame_height == '0) ? CW'(1) : cfg_i.frame_height;

  assign col_nxt   = EW'(col_q) + EW'(1);
  assign row_nxt   = row_q + CW'(1);
  assign row_end   = (col_nxt >= eff_w);
  assign has_right = !row_end;

  // classification
  assign st_go    = st_valid_q && !q_full_i;
  assign full_o   = st_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign is_pix   = accept && (item_i.cmd == rbo_pkg::CmdPixel) && !drain_q;
  assign is_drn   = accept && (item_i.cmd == rbo_pkg::CmdDrain) && drain_q;
  assign emit     = (is_pix && (row_q != '0)) || is_drn;

  always_comb begin
    nbr_d.has_left  = (col_q != '0);
    nbr_d.has_right = has_right;
    if (drain_q) begin
      nbr_d.has_below = 1'b0;
      nbr_d.has_up    = (eff_h > CW'(1));
      nbr_d.last      = row_end;
    end else begin
      nbr_d.has_below = 1'b1;
      nbr_d.has_up    = (row_q > CW'(1));
      nbr_d.last      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else if (restart_i) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else if (is_pix) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= row_nxt;
        if (row_nxt >= eff_h) begin
          drain_q <= 1'b1;
        end
      end else begin
        col_q <= col_nxt[AW-1:0];
      end
    end else if (is_drn) begin
      if (row_end) begin
        col_q   <= '0;
        row_q   <= '0;
        drain_q <= 1'b0;
      end else begin
        col_q <= col_nxt[AW-1:0];
      end
    end
  end

  // label rows alternate between two banks by row parity
  assign par    = row_q[0];
  assign addr_c = col_q;
  assign addr_r = has_right ? col_nxt[AW-1:0] : col_q;
  assign lab_in = LabelBits'(item_i.region_label);
  assign rgb_in = {item_i.in_red, item_i.in_green, item_i.in_blue};

  always_ff @(posedge clk_i) begin
    if (is_pix && !par) begin
      bank0[addr_c] <= lab_in;
    end
    if (emit) begin
      b0_a_q <= bank0[addr_c];
      b0_b_q <= bank0[addr_r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_pix && par) begin
      bank1[addr_c] <= lab_in;
    end
    if (emit) begin
      b1_a_q <= bank1[addr_c];
      b1_b_q <= bank1[addr_r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_pix) begin
      color_mem[addr_c] <= rgb_in;
    end
    if (emit) begin
      color_rd_q <= color_mem[addr_c];
    end
  end

  // neighbor compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (emit) begin
      st_valid_q <= 1'b1;
    end else if (st_go) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      st_nbr_q   <= nbr_d;
      st_below_q <= lab_in;
      st_par_q   <= par;
    end
    if (st_go) begin
      prev_me_q <= me;
    end
  end

  assign me    = st_par_q ? b0_a_q : b1_a_q;
  assign right = st_par_q ? b0_b_q : b1_b_q;
  assign up    = st_par_q ? b1_a_q : b0_a_q;

  assign q_push_o          = st_go;
  assign q_data_o.rgb      = color_rd_q;
  assign q_data_o.last     = st_nbr_q.last;
  assign q_data_o.boundary = (st_nbr_q.has_below && (st_below_q != me)) ||
                             (st_nbr_q.has_left  && (prev_me_q != me))  ||
                             (st_nbr_q.has_right && (right != me))      ||
                             (st_nbr_q.has_up    && (up != me));

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(col_q) < eff_w)
    else $error("column counter beyond frame width");

  a_drain_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (row_q == eff_h))
    else $error("draining without a complete frame");

endmodule

### hw/rtl/rbo_queue.sv
module rbo_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rbo_pkg::work_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output rbo_pkg::work_t data_o,
  output logic           empty_o
);

  localparam int unsigned Depth = rbo_pkg::QueueDepth;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW    = $clog2(Depth + 1);

  rbo_pkg::work_t slot_q [Depth];
  logic [PW-1:0]  wr_q;
  logic [PW-1:0]  rd_q;
  logic [NW-1:0]  cnt_q;
  logic           push_ok;
  logic           pop_ok;

  assign full_o  = (cnt_q == NW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) begin
        wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_ok) begin
        rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + NW'(1);
        2'b01:   cnt_q <= cnt_q - NW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(Depth))
    else $error("queue count over depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_ok) |=> (cnt_q == $past(cnt_q) + NW'(1)))
    else $error("queue count lost a push");

endmodule

### hw/rtl/rbo_back.sv
module rbo_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rbo_pkg::GainBits-1:0]     gain_i,
  input  logic                             q_empty_i,
  input  rbo_pkg::work_t                   q_data_i,
  output logic                             q_pop_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output rbo_pkg::out_item_t               result_o
);

  localparam int unsigned GW = rbo_pkg::GainBits;
  localparam int unsigned PB = 8 + GW;

  function automatic logic [7:0] dim_chan(logic [7:0] c, logic [GW-1:0] g);
    logic [PB-1:0] prod;
    prod = PB'(c) * PB'(g);
    if (prod[PB-1:16] != '0) begin
      return rbo_pkg::ChanMax;
    end
    return prod[15:8];
  endfunction

  logic                 out_valid_q;
  rbo_pkg::out_item_t   out_q;
  rbo_pkg::out_item_t   out_d;
  logic                 load;

  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = load;

  always_comb begin
    if (q_data_i.boundary) begin
      out_d.out_red   = rbo_pkg::ChanMax;
      out_d.out_green = rbo_pkg::ChanMax;
      out_d.out_blue  = rbo_pkg::ChanMax;
    end else begin
      out_d.out_red   = dim_chan(q_data_i.rgb[23:16], gain_i);
      out_d.out_green = dim_chan(q_data_i.rgb[15:8], gain_i);
      out_d.out_blue  = dim_chan(q_data_i.rgb[7:0], gain_i);
    end
    out_d.on_boundary = q_data_i.boundary;
    out_d.frame_end   = q_data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

endmodule

### hw/rtl/region_boundary_overlay.sv
// Region boundary overlay for a raster RGB stream with one region label per pixel.
// A pixel whose label differs from its left, right, upper or lower neighbor inside the
// frame comes out white with on_boundary set; every other pixel has each channel scaled
// by dim_gain/256, saturating at 255. Push pixels (cmd 0) in raster order; a pixel comes
// out once the pixel below it has been pushed, so the first row produces nothing until
// the second arrives. Once the last row is in, pixels are ignored and one drain item
// (cmd 1) per pixel emits the final row, frame_end marking its last pixel; drain items
// outside that phase are ignored. Both sides work like a queue: one item per clock is
// accepted and one result per clock delivered for as long as results are popped; each
// result passes from the row buffer reads through the neighbor compare stage, the queue
// and the output register. Each column writes one row buffer entry and reads two per bank.
// The row buffers need no clearing after reset. Writing frame_width or frame_height
// restarts the frame; a width of 0 acts as 1, a width above MaxWidth as MaxWidth, a
// height of 0 as 1. Configuration is meant to be written only while the block is idle.
module region_boundary_overlay #(
  parameter int unsigned MaxWidth  = rbo_pkg::MaxWidthDef,
  parameter int unsigned LabelBits = rbo_pkg::LabelBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  rbo_pkg::in_item_t              item_i,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output rbo_pkg::out_item_t             result_o,
  input  logic                           cfg_we_i,
  input  logic [rbo_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [rbo_pkg::CfgBits-1:0]    cfg_data_i
);

  rbo_pkg::cfg_t  cfg_q;
  logic           restart;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  rbo_pkg::work_t q_wdata;
  rbo_pkg::work_t q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= rbo_pkg::WidthReset;
      cfg_q.frame_height <= rbo_pkg::HeightReset;
      cfg_q.dim_gain     <= rbo_pkg::GainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbo_pkg::RegFrameWidth:  cfg_q.frame_width  <= cfg_data_i;
        rbo_pkg::RegFrameHeight: cfg_q.frame_height <= cfg_data_i;
        rbo_pkg::RegDimGain:     cfg_q.dim_gain     <= cfg_data_i[rbo_pkg::GainBits-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == rbo_pkg::RegFrameWidth) ||
                                (cfg_idx_i == rbo_pkg::RegFrameHeight));

  rbo_front #(
    .MaxWidth  (MaxWidth),
    .LabelBits (LabelBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (restart),
    .push_i    (push),
    .item_i    (item_i),
    .full_o    (full),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  rbo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  rbo_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gain_i    (cfg_q.dim_gain),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result_o)
  );

endmodule

### tb/region_boundary_overlay_checker.sv
`timescale 1ns / 100ps

module region_boundary_overlay_checker #(
  parameter int unsigned MaxWidth = rbo_pkg::MaxWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  rbo_pkg::in_item_t              item_i,
  input  logic                           pop_i,
  input  logic                           empty_i,
  input  rbo_pkg::out_item_t             result_i,
  input  logic                           cfg_we_i,
  input  logic [rbo_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [rbo_pkg::CfgBits-1:0]    cfg_data_i,
  output int                             mismatch_count_o,
  output int                             outstanding_o
);

  logic [15:0]                  label_above [MaxWidth];
  logic [15:0]                  label_held  [MaxWidth];
  logic [23:0]                  color_held  [MaxWidth];
  int unsigned                  col_q;
  int unsigned                  row_q;
  bit                           drain_q;
  logic [rbo_pkg::CfgBits-1:0]  width_q;
  logic [rbo_pkg::CfgBits-1:0]  height_q;
  logic [rbo_pkg::GainBits-1:0] gain_q;
  rbo_pkg::out_item_t           pending_pixels [$];
  int                           mismatches;

  function automatic logic [7:0] dim_channel(logic [7:0] c,
                                             logic [rbo_pkg::GainBits-1:0] gain);
    logic [16:0] prod;
    prod = 17'(c) * 17'(gain);
    if (prod[16:8] > 9'd255) return rbo_pkg::ChanMax;
    return prod[15:8];
  endfunction

  function automatic rbo_pkg::out_item_t overlay_pixel(logic [23:0] rgb, logic boundary,
                                                       logic last);
    rbo_pkg::out_item_t px;
    if (boundary) begin
      px.out_red   = rbo_pkg::ChanMax;
      px.out_green = rbo_pkg::ChanMax;
      px.out_blue  = rbo_pkg::ChanMax;
    end else begin
      px.out_red   = dim_channel(rgb[23:16], gain_q);
      px.out_green = dim_channel(rgb[15:8], gain_q);
      px.out_blue  = dim_channel(rgb[7:0], gain_q);
    end
    px.on_boundary = boundary;
    px.frame_end   = last;
    return px;
  endfunction

  task automatic rewind_frame();
    col_q   = 0;
    row_q   = 0;
    drain_q = 1'b0;
  endtask

  task automatic predict_overlay(rbo_pkg::in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic [15:0] me;
    logic        boundary;
    w = (width_q == 0) ? 1 : ((width_q > MaxWidth) ? MaxWidth : width_q);
    h = (height_q == 0) ? 1 : height_q;
    c = col_q;
    if (c >= w) begin
      rewind_frame();
      c = 0;
    end
    if (!drain_q) begin
      if (it.cmd == rbo_pkg::CmdDrain) return;
      if (row_q > 0) begin
        me = label_held[c];
        boundary = (it.region_label != me);
        if (c > 0 && label_above[c-1] != me) boundary = 1'b1;
        if (c + 1 < w && label_held[c+1] != me) boundary = 1'b1;
        if (row_q > 1 && label_above[c] != me) boundary = 1'b1;
        pending_pixels.push_back(overlay_pixel(color_held[c], boundary, 1'b0));
        label_above[c] = me;
      end
      label_held[c] = it.region_label;
      color_held[c] = {it.in_red, it.in_green, it.in_blue};
      col_q = c + 1;
      if (col_q >= w) begin
        col_q = 0;
        row_q++;
        if (row_q >= h) drain_q = 1'b1;
      end
    end else if (it.cmd == rbo_pkg::CmdDrain) begin
      me = label_held[c];
      boundary = 1'b0;
      if (c > 0 && label_held[c-1] != me) boundary = 1'b1;
      if (c + 1 < w && label_held[c+1] != me) boundary = 1'b1;
      if (h > 1 && label_above[c] != me) boundary = 1'b1;
      pending_pixels.push_back(overlay_pixel(color_held[c], boundary, c + 1 >= w));
      col_q = c + 1;
      if (col_q >= w) rewind_frame();
    end
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rbo_pkg::out_item_t exp_px;
    if (!rst_ni) begin
      rewind_frame();
      width_q  = rbo_pkg::WidthReset;
      height_q = rbo_pkg::HeightReset;
      gain_q   = rbo_pkg::GainReset;
      pending_pixels.delete();
      mismatches = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel came out with none expected");
          mismatches++;
        end else begin
          exp_px = pending_pixels.pop_front();
          check_field("out_red", exp_px.out_red, result_i.out_red);
          check_field("out_green", exp_px.out_green, result_i.out_green);
          check_field("out_blue", exp_px.out_blue, result_i.out_blue);
          check_field("on_boundary", exp_px.on_boundary, result_i.on_boundary);
          check_field("frame_end", exp_px.frame_end, result_i.frame_end);
        end
      end
      if (push_i && !full_i) predict_overlay(item_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbo_pkg::RegFrameWidth: begin
            width_q = cfg_data_i;
            rewind_frame();
          end
          rbo_pkg::RegFrameHeight: begin
            height_q = cfg_data_i;
            rewind_frame();
          end
          rbo_pkg::RegDimGain: begin
            gain_q = cfg_data_i[rbo_pkg::GainBits-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= pending_pixels.size();
  end

endmodule

### tb/region_boundary_overlay_tb.sv
`timescale 1ns / 100ps

module region_boundary_overlay_tb;

  logic                           clk;
  logic                           rst_n;
  logic                           push;
  logic                           full;
  logic                           empty;
  logic                           pop;
  rbo_pkg::in_item_t              in_item;
  rbo_pkg::out_item_t             out_item;
  logic                           cfg_we;
  logic [rbo_pkg::CfgIdxBits-1:0] cfg_idx;
  logic [rbo_pkg::CfgBits-1:0]    cfg_data;

  int                             mismatches;
  int                             outstanding;
  bit                             idle_on;
  bit                             stall_on;
  int                             frame_items;
  logic [rbo_pkg::CfgBits-1:0]    cur_w;
  logic [rbo_pkg::CfgBits-1:0]    cur_h;

  region_boundary_overlay dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .item_i     (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .result_o   (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  region_boundary_overlay_checker overlay_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .item_i           (in_item),
    .pop_i            (pop),
    .empty_i          (empty),
    .result_i         (out_item),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [rbo_pkg::GainBits-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 9'd256;
      2: return 9'd511;
      3: return rbo_pkg::GainReset;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic rbo_pkg::in_item_t make_item(rbo_pkg::cmd_e cmd, logic [15:0] label,
                                                  logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
    rbo_pkg::in_item_t it;
    it.cmd          = cmd;
    it.in_red       = r;
    it.in_green     = g;
    it.in_blue      = b;
    it.region_label = label;
    return it;
  endfunction

  function automatic rbo_pkg::in_item_t random_item(rbo_pkg::cmd_e cmd);
    return make_item(cmd, 16'($urandom), rand_channel(), rand_channel(), rand_channel());
  endfunction

  function automatic int unsigned eff_width(logic [rbo_pkg::CfgBits-1:0] w);
    return (w == 0) ? 1 : ((w > rbo_pkg::MaxWidthDef) ? rbo_pkg::MaxWidthDef : w);
  endfunction

  task automatic send_item(rbo_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(bit wr_w, logic [rbo_pkg::CfgBits-1:0] w, bit wr_h,
                            logic [rbo_pkg::CfgBits-1:0] h, bit wr_g,
                            logic [rbo_pkg::GainBits-1:0] g);
    if (wr_w) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= rbo_pkg::RegFrameWidth;
      cfg_data <= w;
      cur_w = w;
      @(posedge clk);
    end
    if (wr_h) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= rbo_pkg::RegFrameHeight;
      cfg_data <= h;
      cur_h = h;
      @(posedge clk);
    end
    if (wr_g) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= rbo_pkg::RegDimGain;
      cfg_data <= rbo_pkg::CfgBits'(g);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one frame of labeled pixels then its drain; stop_at >= 0 cuts it short
  task automatic run_frame(int w, int h, int stop_at);
    logic [15:0] lab_a;
    logic [15:0] lab_b;
    logic [15:0] lab_c;
    logic [15:0] lab;
    int          scheme;
    int          split_col;
    int          split_row;
    int          k;
    lab_a     = 16'($urandom);
    lab_b     = lab_a ^ (16'h1 << $urandom_range(0, 15));
    lab_c     = 16'($urandom);
    scheme    = $urandom_range(0, 3);
    split_col = $urandom_range(0, w);
    split_row = $urandom_range(0, h);
    k = 0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (k == stop_at) return;
        if ($urandom_range(0, 15) == 0) send_item(random_item(rbo_pkg::CmdDrain));
        case (scheme)
          0: lab = lab_a;
          1: lab = (x < split_col) ? lab_a : lab_b;
          2: lab = (y < split_row) ? lab_a : lab_c;
          default: begin
            case ($urandom_range(0, 2))
              0: lab = lab_a;
              1: lab = lab_b;
              default: lab = lab_c;
            endcase
          end
        endcase
        if ($urandom_range(0, 19) == 0) lab = 16'($urandom);
        send_item(make_item(rbo_pkg::CmdPixel, lab, rand_channel(), rand_channel(),
                            rand_channel()));
        k++;
        frame_items++;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(random_item(rbo_pkg::CmdPixel));
    end
    for (int x = 0; x < w; x++) begin
      if (k == stop_at) return;
      if ($urandom_range(0, 15) == 0) send_item(random_item(rbo_pkg::CmdPixel));
      send_item(random_item(rbo_pkg::CmdDrain));
      k++;
      frame_items++;
    end
  endtask

  initial begin : result_drain
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [rbo_pkg::CfgBits-1:0] new_w;
    logic [rbo_pkg::CfgBits-1:0] new_h;
    logic [1:0]                  geo_sel;
    int                          stop_at;
    int                          waited;
    bit                          mid_frame;
    rst_n    <= 1'b0;
    push     <= 1'b0;
    in_item  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= rbo_pkg::RegFrameWidth;
    cfg_data <= '0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    frame_items = 0;
    cur_w       = rbo_pkg::WidthReset;
    cur_h       = rbo_pkg::HeightReset;
    mid_frame   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero width and height act as one pixel, unity gain
    write_regs(1'b1, '0, 1'b1, '0, 1'b1, 9'd256);
    send_item(make_item(rbo_pkg::CmdDrain, 16'h1234, 8'h11, 8'h22, 8'h33));
    send_item(make_item(rbo_pkg::CmdPixel, 16'hFFFF, 8'hFF, 8'h00, 8'h80));
    send_item(make_item(rbo_pkg::CmdPixel, 16'h0000, 8'h01, 8'h02, 8'h03));
    send_item(make_item(rbo_pkg::CmdDrain, 16'h0000, 8'h00, 8'h00, 8'h00));
    settle();

    // saturating gain on a 3x2 frame
    write_regs(1'b1, 11'd3, 1'b1, 11'd2, 1'b1, 9'd511);
    send_item(make_item(rbo_pkg::CmdPixel, 16'h0000, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(rbo_pkg::CmdPixel, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_item(make_item(rbo_pkg::CmdPixel, 16'hFFFF, 8'h80, 8'h7F, 8'h01));
    send_item(make_item(rbo_pkg::CmdDrain, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(rbo_pkg::CmdPixel, 16'h0000, 8'hFE, 8'h01, 8'hFF));
    send_item(make_item(rbo_pkg::CmdPixel, 16'h8000, 8'h10, 8'h20, 8'h30));
    send_item(make_item(rbo_pkg::CmdPixel, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    repeat (3) send_item(random_item(rbo_pkg::CmdDrain));
    settle();

    // single row, zero gain
    write_regs(1'b1, 11'd3, 1'b1, 11'd1, 1'b1, 9'd0);
    send_item(make_item(rbo_pkg::CmdPixel, 16'hAAAA, 8'hFF, 8'h80, 8'h01));
    send_item(make_item(rbo_pkg::CmdPixel, 16'hAAAA, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(rbo_pkg::CmdPixel, 16'h5555, 8'h7F, 8'h00, 8'hFF));
    repeat (3) send_item(random_item(rbo_pkg::CmdDrain));
    settle();

    // widest row, clamped from the largest width value
    write_regs(1'b1, 11'h7FF, 1'b1, 11'd1, 1'b1, pick_gain());
    run_frame(eff_width(cur_w), 1, -1);
    settle();

    // tallest frame, given up after a few rows
    write_regs(1'b1, 11'd2, 1'b1, 11'h7FF, 1'b0, '0);
    run_frame(2, 2047, 9);
    settle();
    write_regs(1'b1, 11'd4, 1'b1, 11'd3, 1'b1, rbo_pkg::GainReset);

    frame_items = 0;
    while (frame_items < 1150) begin
      if (frame_items > 1000) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      settle();
      if (mid_frame || $urandom_range(0, 2) != 0) begin
        geo_sel = 2'($urandom_range(1, 3));
        case ($urandom_range(0, 9))
          0: new_w = '0;
          1: new_w = 11'($urandom_range(13, 64));
          default: new_w = 11'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 19))
          0, 1: new_h = '0;
          2: new_h = 11'($urandom_range(7, 20));
          default: new_h = 11'($urandom_range(1, 6));
        endcase
        write_regs(geo_sel[0], new_w, geo_sel[1], new_h, 1'($urandom_range(0, 1)),
                   pick_gain());
      end else begin
        write_regs(1'b0, '0, 1'b0, '0, $urandom_range(0, 2) == 0, pick_gain());
      end
      stop_at = -1;
      if ($urandom_range(0, 5) == 0) begin
        stop_at = $urandom_range(0, eff_width(cur_w) * ((cur_h == 0) ? 1 : cur_h)
                                    + eff_width(cur_w) - 1);
      end
      mid_frame = (stop_at >= 0);
      run_frame(eff_width(cur_w), (cur_h == 0) ? 1 : cur_h, stop_at);
    end

    idle_on  = 1'b0;
    stall_on = 1'b0;
    push <= 1'b0;
    for (waited = 0; waited < 5000 && outstanding != 0; waited++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (outstanding != 0) $error("%0d expected pixels never came out", outstanding);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
